// ----- hdl/fewest_hop_most_reliable_path_assert.svh -----
// Assertion macros for the path search block
`ifndef FEWEST_HOP_MOST_RELIABLE_PATH_ASSERT_SVH
`define FEWEST_HOP_MOST_RELIABLE_PATH_ASSERT_SVH

// implication checked on every clock edge out of reset
`define FHP_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%s failed", "label");

// implication checked in the next cycle
`define FHP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%s failed", "label");

`endif

// ----- hdl/fhp_pkg.sv -----
package fhp_pkg;

  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned MaxLinksDef = 256;
  localparam int unsigned ProbFracBitsDef = 16;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOURCE = 1'b0,
    REG_TARGET = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       cmd;
    logic [5:0] end_a;
    logic [5:0] end_b;
    logic [6:0] loss_percent;
  } fhp_req_t;

  typedef struct packed {
    logic [5:0]  route_node;
    logic [6:0]  hop_count;
    logic [16:0] fail_prob;
    logic        reachable;
    logic        last;
  } fhp_res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_INIT,
    ST_POP,
    ST_POP_RD,
    ST_EDGE_RD,
    ST_EDGE_WT,
    ST_EDGE_NODE,
    ST_EDGE_MUL,
    ST_EDGE_CMP,
    ST_WALK,
    ST_WALK_RD,
    ST_EMIT_RD,
    ST_EMIT,
    ST_UNREACH
  } fhp_state_e;

  // controller to datapath
  typedef struct packed {
    logic add_check;
    logic add_a;
    logic add_b;
    logic init_clr;
    logic init_seed;
    logic pop;
    logic pop_rd;
    logic edge_rd;
    logic edge_node;
    logic edge_mul;
    logic edge_cmp;
    logic walk_start;
    logic walk_step;
    logic walk_rd;
    logic emit_rd;
    logic emit;
    logic unreach;
  } fhp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic add_ok;
    logic init_done;
    logic run_bad;
    logic queue_empty;
    logic edge_end;
    logic target_unset;
    logic walk_done;
    logic emit_last;
  } fhp_sts_t;

endpackage

// ----- hdl/fhp_ctrl.sv -----
module fhp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              cmd_i,
  input  fhp_pkg::fhp_sts_t sts_i,
  output fhp_pkg::fhp_cmd_t ctl_o,
  output logic              busy_o
);
  import fhp_pkg::*;

  fhp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_RUN) begin
            ctl_o.init_clr = 1'b1;
            state_d = ST_INIT;
          end else begin
            ctl_o.add_check = 1'b1;
            state_d = ST_ADD_A;
          end
        end
      end
      ST_ADD_A: begin
        if (sts_i.add_ok) begin
          ctl_o.add_a = 1'b1;
          state_d = ST_ADD_B;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD_B: begin
        ctl_o.add_b = 1'b1;
        state_d = ST_IDLE;
      end
      ST_INIT: begin
        if (sts_i.init_done) begin
          if (sts_i.run_bad) begin
            state_d = ST_UNREACH;
          end else begin
            ctl_o.init_seed = 1'b1;
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (sts_i.queue_empty) begin
          if (sts_i.target_unset) begin
            state_d = ST_UNREACH;
          end else begin
            ctl_o.walk_start = 1'b1;
            state_d = ST_WALK_RD;
          end
        end else begin
          ctl_o.pop = 1'b1;
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        ctl_o.pop_rd = 1'b1;
        state_d = ST_EDGE_RD;
      end
      ST_EDGE_RD: begin
        if (sts_i.edge_end) begin
          state_d = ST_POP;
        end else begin
          ctl_o.edge_rd = 1'b1;
          state_d = ST_EDGE_WT;
        end
      end
      ST_EDGE_WT: state_d = ST_EDGE_NODE;
      ST_EDGE_NODE: begin
        ctl_o.edge_node = 1'b1;
        state_d = ST_EDGE_MUL;
      end
      ST_EDGE_MUL: begin
        ctl_o.edge_mul = 1'b1;
        state_d = ST_EDGE_CMP;
      end
      ST_EDGE_CMP: begin
        ctl_o.edge_cmp = 1'b1;
        state_d = ST_EDGE_RD;
      end
      ST_WALK_RD: begin
        ctl_o.walk_rd = 1'b1;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          ctl_o.emit_rd = 1'b1;
          state_d = ST_EMIT_RD;
        end else begin
          ctl_o.walk_step = 1'b1;
          state_d = ST_WALK_RD;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        ctl_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          state_d = ST_IDLE;
        end else begin
          ctl_o.emit_rd = 1'b1;
          state_d = ST_EMIT_RD;
        end
      end
      ST_UNREACH: begin
        ctl_o.unreach = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/fhp_datapath.sv -----
module fhp_datapath #(
  parameter int unsigned MaxLinks = fhp_pkg::MaxLinksDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fhp_pkg::fhp_req_t req_i,
  input  logic              start_i,
  input  logic [5:0]        source_i,
  input  logic [5:0]        target_i,
  input  fhp_pkg::fhp_cmd_t ctl_i,
  output fhp_pkg::fhp_sts_t sts_o,
  output logic              res_valid_o,
  output fhp_pkg::fhp_res_t res_o
);
  import fhp_pkg::*;

  localparam int unsigned MaxNodes = MaxNodesDef;
  localparam int unsigned ProbFracBits = ProbFracBitsDef;
  localparam int unsigned NodeW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned NodeXW = $clog2(MaxNodes + 1);
  localparam int unsigned Slots = 2 * MaxLinks;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned SlotXW = $clog2(Slots + 1);
  localparam int unsigned ProbW = ProbFracBits + 1;
  localparam int unsigned HopW = $clog2(MaxNodes + 1);
  localparam logic [HopW-1:0] HopsInf = '1;
  localparam logic [ProbW-1:0] ProbOne = ProbW'(1) << ProbFracBits;
  localparam logic [SlotXW-1:0] NoLink = SlotXW'(Slots);
  localparam logic [NodeXW-1:0] NoNode = NodeXW'(MaxNodes);
  localparam int unsigned RelNumW = 7 + ProbFracBits;
  localparam int unsigned RecipW = RelNumW + 8;
  // reciprocal of 100, scaled by 2^(RelNumW+7), held in RelNumW+8 bits
  localparam logic [RecipW-1:0] Recip100 =
    RecipW'(((64'd1 << (RelNumW + 7)) + 64'd99) / 64'd100);

  // link store
  logic [SlotXW-1:0] chain_mem [Slots];
  logic [NodeW-1:0]  dest_mem  [Slots];
  logic [ProbW-1:0]  rel_mem   [Slots];
  // per-node stores
  logic [SlotXW-1:0] head_mem  [MaxNodes];
  logic [HopW-1:0]   hops_mem  [MaxNodes];
  logic [ProbW-1:0]  prod_mem  [MaxNodes];
  logic [NodeXW-1:0] par_mem   [MaxNodes];
  logic [NodeW-1:0]  queue_mem [MaxNodes];
  logic [NodeW-1:0]  stack_mem [MaxNodes];
  logic [MaxNodes-1:0] head_vld_q;
  logic [MaxNodes-1:0] mark_q;

  logic [SlotXW-1:0] used_q;
  logic [NodeW-1:0]  a_q, b_q;
  logic [ProbW-1:0]  rel_q;
  logic [NodeW-1:0]  init_q;
  logic              init_done_q;
  logic [NodeW-1:0]  qhead_q;
  logic [NodeXW-1:0] qcount_q;
  logic [NodeW-1:0]  x_q, to_q;
  logic [HopW-1:0]   xh_q, toh_q;
  logic [ProbW-1:0]  xp_q, top_q, erel_q, p_q;
  logic [SlotXW-1:0] e_q;
  logic [NodeW-1:0]  s_q, t_q;
  logic [NodeXW-1:0] cur_q;
  logic [NodeXW-1:0] n_q, i_q;
  logic [ProbW-1:0]  fail_q;
  logic [SlotXW-1:0] rd_chain_q;
  logic [NodeW-1:0]  rd_dest_q;
  logic [ProbW-1:0]  rd_rel_q;
  logic [HopW-1:0]   rd_hops_q;
  logic [ProbW-1:0]  rd_prod_q;
  logic [HopW-1:0]   rd_nhops_q;
  logic [ProbW-1:0]  rd_nprod_q;
  logic [NodeXW-1:0] rd_par_q;
  logic [NodeW-1:0]  rd_stack_q;
  logic [NodeW-1:0]  rd_queue_q;
  logic [SlotXW-1:0] rd_head_q;
  logic              rd_head_vld_q;
  logic              res_valid_q;
  fhp_res_t          res_q;

  // reliability: (100-loss)<<F / 100 by reciprocal
  logic [6:0]          loss_sat;
  logic [RelNumW-1:0]  rel_num;
  logic [RecipW+RelNumW-1:0] rel_prod;
  logic [ProbW-1:0]    rel_calc;
  always_comb begin
    loss_sat = (req_i.loss_percent > 7'd100) ? 7'd100 : req_i.loss_percent;
    rel_num  = RelNumW'(7'd100 - loss_sat) << ProbFracBits;
    rel_prod = RecipW'(Recip100) * rel_num;
    rel_calc = ProbW'(rel_prod >> (RelNumW + 7));
  end

  logic [2*ProbW-1:0] mul;
  logic [HopW-1:0]    h_new;
  logic               better;
  always_comb begin
    mul    = xp_q * erel_q;
    h_new  = xh_q + HopW'(1);
    better = (h_new < toh_q) || ((h_new == toh_q) && (p_q > top_q));
  end

  // queue tail slot, wrapped by compare and subtract
  logic [NodeXW-1:0] qsum;
  logic [NodeW-1:0]  wslot;
  assign qsum  = NodeXW'(qhead_q) + qcount_q;
  assign wslot = (qsum >= NodeXW'(MaxNodes)) ? NodeW'(qsum - NodeXW'(MaxNodes)) :
                                               NodeW'(qsum);

  // read addresses: adjacency head and popped node / target
  logic [NodeW-1:0]  hd_addr;
  logic [NodeW-1:0]  nrd_addr;
  logic [SlotXW-1:0] head_lnk;
  always_comb begin
    if (ctl_i.add_check) begin
      hd_addr = NodeW'(req_i.end_a);
    end else if (ctl_i.add_a) begin
      hd_addr = b_q;
    end else if (ctl_i.pop) begin
      hd_addr = rd_queue_q;
    end else begin
      hd_addr = x_q;
    end
    nrd_addr = ctl_i.pop ? rd_queue_q : t_q;
    head_lnk = rd_head_vld_q ? rd_head_q : NoLink;
  end

  always_comb begin
    sts_o              = '0;
    sts_o.add_ok       = (used_q + SlotXW'(2) <= NoLink) &&
                         (32'(a_q) < MaxNodes) && (32'(b_q) < MaxNodes);
    sts_o.init_done    = init_done_q;
    sts_o.run_bad      = (32'(s_q) >= MaxNodes) || (32'(t_q) >= MaxNodes);
    sts_o.queue_empty  = (qcount_q == '0);
    sts_o.edge_end     = (e_q >= NoLink);
    sts_o.target_unset = (rd_nhops_q == HopsInf);
    sts_o.walk_done    = (cur_q >= NoNode) || (n_q >= NodeXW'(MaxNodes));
    sts_o.emit_last    = (i_q + NodeXW'(1) == n_q);
  end

  // link store, a single write or read port per array
  always_ff @(posedge clk_i) begin
    if (ctl_i.add_a || ctl_i.add_b) begin
      // a self link chains onto the entry written just before
      chain_mem[used_q[SlotW-1:0]] <= (ctl_i.add_b && (a_q == b_q)) ?
        used_q - SlotXW'(1) : head_lnk;
      dest_mem[used_q[SlotW-1:0]] <= ctl_i.add_a ? b_q : a_q;
      rel_mem[used_q[SlotW-1:0]]  <= rel_q;
    end
    if (ctl_i.edge_rd) begin
      rd_chain_q <= chain_mem[e_q[SlotW-1:0]];
      rd_dest_q  <= dest_mem[e_q[SlotW-1:0]];
      rd_rel_q   <= rel_mem[e_q[SlotW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.add_a) head_mem[a_q] <= used_q;
    if (ctl_i.add_b) head_mem[b_q] <= used_q;
    rd_head_q     <= head_mem[hd_addr];
    rd_head_vld_q <= head_vld_q[hd_addr];
    rd_queue_q    <= ctl_i.init_seed ? s_q : queue_mem[qhead_q];
    rd_hops_q     <= hops_mem[rd_dest_q];
    rd_prod_q     <= prod_mem[rd_dest_q];
    rd_nhops_q    <= hops_mem[nrd_addr];
    rd_nprod_q    <= prod_mem[nrd_addr];
    rd_par_q      <= par_mem[cur_q[NodeW-1:0]];
    rd_stack_q    <= stack_mem[NodeW'(n_q - NodeXW'(1) - i_q)];
    if (ctl_i.init_clr || !init_done_q) begin
      hops_mem[init_q] <= HopsInf;
      prod_mem[init_q] <= '0;
      par_mem[init_q]  <= NoNode;
    end
    if (ctl_i.init_seed) begin
      hops_mem[s_q]  <= '0;
      prod_mem[s_q]  <= ProbOne;
      queue_mem[0]   <= s_q;
    end
    if (ctl_i.edge_cmp && better) begin
      hops_mem[to_q] <= h_new;
      prod_mem[to_q] <= p_q;
      par_mem[to_q]  <= NodeXW'(x_q);
      if (!mark_q[to_q] && (to_q != t_q) && (qcount_q < NodeXW'(MaxNodes)))
        queue_mem[wslot] <= to_q;
    end
    if (ctl_i.walk_step) stack_mem[n_q[NodeW-1:0]] <= cur_q[NodeW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q  <= '0;
      mark_q      <= '0;
      used_q      <= '0;
      init_q      <= '0;
      init_done_q <= 1'b1;
      qhead_q     <= '0;
      qcount_q    <= '0;
      e_q         <= NoLink;
      cur_q       <= NoNode;
      n_q         <= '0;
      i_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.emit || ctl_i.unreach;
      if (ctl_i.add_a) head_vld_q[a_q] <= 1'b1;
      if (ctl_i.add_b) head_vld_q[b_q] <= 1'b1;
      if (ctl_i.add_a || ctl_i.add_b) used_q <= used_q + SlotXW'(1);
      // clearing sweep over node tables at run start
      if (ctl_i.init_clr) begin
        init_q      <= NodeW'(1);
        init_done_q <= 1'b0;
        mark_q      <= '0;
        qhead_q     <= '0;
        qcount_q    <= '0;
        n_q         <= '0;
        i_q         <= '0;
      end else if (!init_done_q) begin
        if (32'(init_q) == MaxNodes - 1) begin
          init_done_q <= 1'b1;
          init_q      <= '0;
        end else begin
          init_q <= init_q + NodeW'(1);
        end
      end
      if (ctl_i.init_seed) begin
        mark_q[s_q] <= 1'b1;
        qcount_q    <= NodeXW'(1);
      end
      if (ctl_i.pop) begin
        x_q      <= rd_queue_q;
        mark_q[rd_queue_q] <= 1'b0;
        qhead_q  <= (32'(qhead_q) == MaxNodes - 1) ? '0 : qhead_q + NodeW'(1);
        qcount_q <= qcount_q - NodeXW'(1);
      end
      if (ctl_i.pop_rd) begin
        e_q  <= head_lnk;
        xh_q <= rd_nhops_q;
        xp_q <= rd_nprod_q;
      end
      if (ctl_i.edge_node) begin
        to_q   <= rd_dest_q;
        erel_q <= rd_rel_q;
        e_q    <= rd_chain_q;
      end
      if (ctl_i.edge_mul) begin
        p_q   <= ProbW'(mul >> ProbFracBits);
        toh_q <= rd_hops_q;
        top_q <= rd_prod_q;
      end
      if (ctl_i.edge_cmp && better &&
          !mark_q[to_q] && (to_q != t_q) && (qcount_q < NodeXW'(MaxNodes))) begin
        qcount_q     <= qcount_q + NodeXW'(1);
        mark_q[to_q] <= 1'b1;
      end
      if (ctl_i.walk_start) begin
        cur_q  <= NodeXW'(t_q);
        n_q    <= '0;
        fail_q <= ProbOne - rd_nprod_q;
      end
      if (ctl_i.walk_step) begin
        n_q   <= n_q + NodeXW'(1);
      end
      if (ctl_i.walk_rd) cur_q <= (n_q == '0) ? NodeXW'(t_q) : rd_par_q;
      if (ctl_i.emit) begin
        i_q <= i_q + NodeXW'(1);
      end
    end
  end

  // walk reads parent of the node just pushed
  logic walk_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_rd_q <= 1'b0;
    end else begin
      walk_rd_q <= ctl_i.walk_rd;
    end
  end

  // request latches and result register
  always_ff @(posedge clk_i) begin
    if (start_i && ctl_i.add_check) begin
      a_q   <= NodeW'(req_i.end_a);
      b_q   <= NodeW'(req_i.end_b);
      rel_q <= rel_calc;
    end
    if (ctl_i.init_clr) begin
      s_q <= NodeW'(source_i);
      t_q <= NodeW'(target_i);
    end
    if (ctl_i.emit) begin
      res_q.route_node <= 6'(rd_stack_q);
      res_q.hop_count  <= 7'(n_q);
      res_q.fail_prob  <= 17'(fail_q);
      res_q.reachable  <= 1'b1;
      res_q.last       <= sts_o.emit_last;
    end
    if (ctl_i.unreach) begin
      res_q.route_node <= '0;
      res_q.hop_count  <= '0;
      res_q.fail_prob  <= 17'(ProbOne);
      res_q.reachable  <= 1'b0;
      res_q.last       <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q && !walk_rd_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/fewest_hop_most_reliable_path.sv -----
// Fewest-hop, most-reliable path search over an undirected lossy network.
// Request channel: drive req_i and raise start; the request is taken at a
// clock edge where start is high and busy is low. cmd 0 adds a link as
// two directed entries; cmd 1 runs the search and emits the path from
// source to target.
// Result channel: res_valid_o is high for one cycle per result; the
// receiver must take it then, it cannot hold results off. A run gives one
// result per path node, source first, last set on the final one, or one
// result with reachable clear when the target cannot be reached.
// Configuration: cfg_we_i with cfg_idx_i (0 source, 1 target) and
// cfg_data_i; the user must write only while busy is low, the block does not enforce it.
// Run: a clearing sweep over the node tables, then for each queue pop a
// visit of every link entry of the popped node (one link store port read,
// a registered multiply, one compare), then a walk of the parent pointers
// from the target, then the results.
// Reset clears the link count, the adjacency head valid bits and the control registers.
module fewest_hop_most_reliable_path #(
  parameter int unsigned MaxLinks = fhp_pkg::MaxLinksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  fhp_pkg::fhp_req_t             req_i,
  output logic                          res_valid_o,
  output fhp_pkg::fhp_res_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [fhp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fhp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fhp_pkg::*;
`include "fewest_hop_most_reliable_path_assert.svh"

  logic [5:0] source_q, target_q;
  fhp_cmd_t   ctl;
  fhp_sts_t   sts;
  logic       take;

  assign take = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= '0;
      target_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SOURCE: source_q <= cfg_data_i;
        REG_TARGET: target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fhp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (req_i.cmd),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy)
  );

  fhp_datapath #(
    .MaxLinks     (MaxLinks)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .start_i     (take),
    .source_i    (source_q),
    .target_i    (target_q),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  `FHP_ASSERT_IMP(a_unreach_last, clk_i, rst_ni,
    res_valid_o && !res_o.reachable, res_o.last)
  `FHP_ASSERT_IMP(a_more_busy, clk_i, rst_ni, res_valid_o && !res_o.last, busy)
  `FHP_ASSERT_NEXT(a_last_idles, clk_i, rst_ni, res_valid_o && res_o.last, !res_valid_o)

endmodule
